### hw/rtl/wrrts_pkg.sv
package wrrts_pkg;

  localparam int unsigned TaskSlots = 16;
  localparam int unsigned SlotW = $clog2(TaskSlots);
  localparam int unsigned CntW = $clog2(TaskSlots + 1);

  localparam logic [2:0] ReqAdd = 3'd0;
  localparam logic [2:0] ReqRemove = 3'd1;
  localparam logic [2:0] ReqTerm = 3'd2;
  localparam logic [2:0] ReqWake = 3'd3;
  localparam logic [2:0] ReqBlock = 3'd4;
  localparam logic [2:0] ReqSleep = 3'd5;
  localparam logic [2:0] ReqYield = 3'd6;
  localparam logic [2:0] ReqUnused = 3'd7;

  localparam logic [1:0] StReady = 2'd0;
  localparam logic [1:0] StBlocked = 2'd1;
  localparam logic [1:0] StSleeping = 2'd2;
  localparam logic [1:0] StTerm = 2'd3;

  localparam logic [1:0] ErrOk = 2'd0;
  localparam logic [1:0] ErrFull = 2'd1;
  localparam logic [1:0] ErrWake = 2'd2;
  localparam logic [1:0] ErrNotFound = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  task_id;
    logic [7:0]  weight;
    logic [31:0] sleep_us;
    logic [31:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic [3:0] cur_index;
    logic [7:0] cur_task_id;
    logic       switched;
    logic       none_ready;
    logic       reaped_valid;
    logic [7:0] reaped_task_id;
    logic [1:0] error_code;
    logic [4:0] task_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, clear flags, sleep multiply
    logic pre;       // prep step (full check / state change)
    logic walk;      // one slot step
    logic finish;    // commit result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
  } sts_t;

endpackage

### hw/rtl/wrrts_ctrl.sv
module wrrts_ctrl
  import wrrts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SPre  = 2'd1;
  localparam logic [1:0] SWalk = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = SPre;
        end
      end
      SPre: begin
        cmd_o.pre = 1'b1;
        state_d = SWalk;
      end
      SWalk: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) state_d = SFin;
      end
      SFin: begin
        cmd_o.finish = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= cmd_o.finish;
    end
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;

endmodule

### hw/rtl/wrrts_dp.sv
module wrrts_dp
  import wrrts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  req_t       req_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output rsp_t       rsp_o
);

  logic [9:0] tpu_q;
  req_t       req_q;

  logic [TaskSlots-1:0] vld_q;
  logic [7:0]  tid_q [TaskSlots];
  logic [1:0]  rst_q [TaskSlots];
  logic [31:0] wk_q  [TaskSlots];
  logic [7:0]  wt_q  [TaskSlots];
  logic [CntW-1:0]  used_q;
  logic [SlotW-1:0] cur_q;

  // walk state
  logic [CntW-1:0]  i_q;       // step counter
  logic [SlotW-1:0] n_q;       // scan slot
  logic             active_q;  // this request walks
  logic             scan_q;    // walk is a scan (else add/find)
  logic             stop_q;
  logic [31:0]      wake_q;
  // carried task for add
  logic [7:0]  cid_q, cw_q;
  logic [1:0]  cst_q;
  logic [31:0] cwk_q;
  logic        placed_q;
  logic        found_q;
  logic [SlotW-1:0] fidx_q;

  logic       sw_q, none_q, rv_q;
  logic [7:0] rid_q;
  logic [1:0] err_q;
  logic [1:0] err_out_q;

  logic [SlotW-1:0] iw;
  logic [CntW-1:0]  nnext;
  logic [31:0]      dlt;
  logic             due;

  assign iw = i_q[SlotW-1:0];
  assign nnext = {1'b0, n_q} + CntW'(1);
  assign dlt = wk_q[n_q] - req_q.now_ticks;
  assign due = (dlt == 32'd0) || dlt[31];
  // a scan inspects used_q slots on steps 1..used_q, the current slot last
  assign sts_o.walk_done = !active_q || stop_q ||
                           (scan_q ? (i_q > used_q) :
                            ((i_q >= used_q) || (i_q >= CntW'(TaskSlots))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= 10'd1;
      vld_q <= '0;
      used_q <= '0;
      cur_q <= '0;
    end else begin
      if (cfg_we_i) tpu_q <= cfg_wdata_i;
      if (cmd_i.finish) begin
        if (req_q.req_type == ReqAdd && !found_q && err_q == ErrOk) begin
          if (!placed_q) begin
            vld_q[used_q[SlotW-1:0]] <= 1'b1;
            used_q <= used_q + CntW'(1);
          end
        end else if (req_q.req_type == ReqRemove && found_q) begin
          vld_q[fidx_q] <= 1'b0;
          if ({1'b0, fidx_q} + CntW'(1) == used_q) used_q <= used_q - CntW'(1);
        end
      end
      if (cmd_i.walk && active_q && scan_q && !stop_q && i_q != '0 && i_q <= used_q &&
          vld_q[n_q] && rst_q[n_q] == StTerm) begin
        vld_q[n_q] <= 1'b0;
        if (nnext == used_q) used_q <= used_q - CntW'(1);
      end
      if (cmd_i.walk && active_q && !scan_q && !stop_q && i_q < used_q &&
          req_q.req_type == ReqAdd && !vld_q[iw]) begin
        vld_q[iw] <= 1'b1;
      end
      if (cmd_i.walk && active_q && scan_q && !stop_q && i_q != '0 && i_q <= used_q &&
          vld_q[n_q] && rst_q[n_q] != StBlocked && rst_q[n_q] != StTerm &&
          (rst_q[n_q] != StSleeping || due)) begin
        cur_q <= n_q;
      end
    end
  end

  // Scan stepping: i_q==0 is a first step that only advances n; each later
  // step inspects slot n_q and advances unless it picks or reaps that slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      i_q <= '0;
      stop_q <= 1'b0;
      sw_q <= 1'b0; none_q <= 1'b0; rv_q <= 1'b0; rid_q <= '0;
      err_q <= ErrOk;
      found_q <= 1'b0;
      placed_q <= 1'b0;
      fidx_q <= '0;
      cid_q <= req_i.task_id; cw_q <= req_i.weight; cst_q <= StReady; cwk_q <= '0;
      scan_q <= (req_i.req_type == ReqBlock) || (req_i.req_type == ReqYield) ||
                (req_i.req_type == ReqSleep && req_i.sleep_us != 32'd0);
      active_q <= (req_i.req_type != ReqUnused) &&
                  !(req_i.req_type == ReqSleep && req_i.sleep_us == 32'd0);
      wake_q <= req_i.sleep_us * {22'd0, tpu_q};
    end
    if (cmd_i.pre) begin
      n_q <= cur_q;
      if (scan_q) begin
        none_q <= 1'b1;
        if (req_q.req_type == ReqBlock && vld_q[cur_q]) rst_q[cur_q] <= StBlocked;
        if (req_q.req_type == ReqSleep && vld_q[cur_q]) begin
          rst_q[cur_q] <= StSleeping;
          wk_q[cur_q] <= req_q.now_ticks + wake_q;
        end
      end else if (req_q.req_type == ReqAdd) begin
        // full check: hole below used_count
        if (used_q >= CntW'(TaskSlots) && &vld_q) err_q <= ErrFull;
      end
    end
    if (cmd_i.walk && active_q && !stop_q) begin
      if (scan_q) begin
        if (i_q <= used_q) begin
          if (i_q != '0 && vld_q[n_q] && rst_q[n_q] != StBlocked) begin
            if (rst_q[n_q] == StTerm) begin
              rv_q <= 1'b1; rid_q <= tid_q[n_q]; stop_q <= 1'b1;
            end else if (rst_q[n_q] != StSleeping || due) begin
              rst_q[n_q] <= StReady;
              none_q <= 1'b0;
              sw_q <= (n_q != cur_q);
              stop_q <= 1'b1;
            end
          end
          if (!(i_q != '0 && vld_q[n_q] && rst_q[n_q] != StBlocked &&
                (rst_q[n_q] == StTerm || rst_q[n_q] != StSleeping || due))) begin
            n_q <= (nnext >= used_q) ? '0 : nnext[SlotW-1:0];
            i_q <= i_q + CntW'(1);
          end
        end
      end else if (req_q.req_type == ReqAdd) begin
        if (err_q != ErrOk) stop_q <= 1'b1;
        else if (i_q < used_q) begin
          if (!vld_q[iw]) begin
            tid_q[iw] <= cid_q; wt_q[iw] <= cw_q; rst_q[iw] <= cst_q; wk_q[iw] <= cwk_q;
            placed_q <= 1'b1; stop_q <= 1'b1;
          end else if (cw_q != 8'd0 && cw_q > wt_q[iw]) begin
            tid_q[iw] <= cid_q; wt_q[iw] <= cw_q; rst_q[iw] <= cst_q; wk_q[iw] <= cwk_q;
            cid_q <= tid_q[iw]; cw_q <= wt_q[iw]; cst_q <= rst_q[iw]; cwk_q <= wk_q[iw];
          end
          i_q <= i_q + CntW'(1);
        end else begin
          tid_q[used_q[SlotW-1:0]] <= cid_q; wt_q[used_q[SlotW-1:0]] <= cw_q;
          rst_q[used_q[SlotW-1:0]] <= cst_q; wk_q[used_q[SlotW-1:0]] <= cwk_q;
          stop_q <= 1'b1;
        end
      end else begin
        // id lookup
        if (i_q < used_q && i_q < CntW'(TaskSlots)) begin
          if (vld_q[iw] && tid_q[iw] == req_q.task_id) begin
            found_q <= 1'b1; fidx_q <= iw; stop_q <= 1'b1;
            if (req_q.req_type == ReqTerm) rst_q[iw] <= StTerm;
            else if (req_q.req_type == ReqWake) begin
              if (rst_q[iw] != StBlocked) err_q <= ErrWake;
              else rst_q[iw] <= StReady;
            end
          end
          i_q <= i_q + CntW'(1);
        end else begin
          err_q <= ErrNotFound;
          stop_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) err_out_q <= err_q;
  end

  // Output values are read in the cycle after finish, so that table updates show.
  always_comb begin
    rsp_o = '0;
    rsp_o.cur_index = 4'(cur_q);
    rsp_o.cur_task_id = vld_q[cur_q] ? tid_q[cur_q] : 8'd0;
    rsp_o.switched = sw_q;
    rsp_o.none_ready = none_q;
    rsp_o.reaped_valid = rv_q;
    rsp_o.reaped_task_id = rid_q;
    rsp_o.error_code = err_out_q;
    rsp_o.task_count = 5'(used_q);
  end

endmodule

### hw/rtl/weighted_round_robin_task_scheduler.sv
// Weighted round-robin task scheduler.
// Request channel: drive req_i and raise start; the transaction is taken at
// the first rising edge with start high and busy low, and busy stays high
// while the request is processed.
// Configuration: ticks_per_us_we_i with ticks_per_us_wdata_i writes the sleep
// scale; write only while busy is low.
// Result channel: rsp_o holds the result in the cycle marked by done_o, which is
// high for exactly one cycle. The receiver cannot stall and must take it then.
// Sequence: the accepting edge latches the request; the controller then passes
// through a prep state, a table walk of one slot per step and a finish state,
// and done_o is registered from the finish state. The walk stops early when a
// scan picks or reaps a slot, an add fills a hole or a lookup hits. busy drops
// in the result cycle, so the next transaction can be taken at the same edge
// as the result.
// Reset clears the table valid bits, task count, current slot and sets the
// scale to one.
module weighted_round_robin_task_scheduler
  import wrrts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  input  logic       ticks_per_us_we_i,
  input  logic [9:0] ticks_per_us_wdata_i,
  output logic       done_o,
  output rsp_t       rsp_o
);

  cmd_t cmd;
  sts_t sts;

  wrrts_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd), .busy_o(busy),
    .done_o
  );

  wrrts_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i(ticks_per_us_we_i), .cfg_wdata_i(ticks_per_us_wdata_i),
    .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

endmodule

### verif/weighted_round_robin_task_scheduler_tb.sv
`timescale 1ns / 100ps

module weighted_round_robin_task_scheduler_tb;
  import wrrts_pkg::*;

  // Round-robin task table predictor with a queue of expected responses.
  class sched_scoreboard;
    logic [9:0]  tick_scale;
    logic        slot_used [TaskSlots];
    logic [7:0]  slot_id   [TaskSlots];
    logic [1:0]  slot_st   [TaskSlots];
    logic [31:0] slot_wake [TaskSlots];
    logic [7:0]  slot_wt   [TaskSlots];
    int unsigned nslots;
    int unsigned cur_slot;
    rsp_t        pending_rsp[$];
    int          err_cnt;

    function new();
      tick_scale = 10'd1;
      for (int i = 0; i < TaskSlots; i++) begin
        slot_used[i] = 1'b0;
        slot_id[i] = '0;
        slot_st[i] = StReady;
        slot_wake[i] = '0;
        slot_wt[i] = '0;
      end
      nslots = 0;
      cur_slot = 0;
      err_cnt = 0;
    endfunction

    function int lookup_id(logic [7:0] id);
      for (int i = 0; i < nslots && i < TaskSlots; i++)
        if (slot_used[i] && slot_id[i] == id) return i;
      return -1;
    endfunction

    function void drop(int unsigned i);
      slot_used[i] = 1'b0;
      if (i + 1 == nslots) nslots--;
    endfunction

    function void fill(int unsigned i, logic [7:0] id, logic [7:0] w, logic [1:0] st,
                       logic [31:0] wk);
      slot_used[i] = 1'b1;
      slot_id[i] = id;
      slot_wt[i] = w;
      slot_st[i] = st;
      slot_wake[i] = wk;
    endfunction

    function logic [1:0] insert_task(logic [7:0] id, logic [7:0] w);
      logic [7:0]  cid, cw, tid, tw;
      logic [1:0]  cst, tst;
      logic [31:0] cwk, twk;
      bit          has_hole;
      cid = id; cw = w; cst = StReady; cwk = '0;
      has_hole = 0;
      for (int i = 0; i < nslots && i < TaskSlots; i++)
        if (!slot_used[i]) has_hole = 1;
      if (nslots >= TaskSlots && !has_hole) return ErrFull;
      for (int i = 0; i < nslots && i < TaskSlots; i++) begin
        if (!slot_used[i]) begin
          fill(i, cid, cw, cst, cwk);
          return ErrOk;
        end
        if (cw != 0 && cw > slot_wt[i]) begin
          tid = slot_id[i]; tw = slot_wt[i]; tst = slot_st[i]; twk = slot_wake[i];
          fill(i, cid, cw, cst, cwk);
          cid = tid; cw = tw; cst = tst; cwk = twk;
        end
      end
      fill(nslots, cid, cw, cst, cwk);
      nslots++;
      return ErrOk;
    endfunction

    // Round-robin pick starting after the current slot.
    function void pick_next(logic [31:0] now, ref rsp_t r);
      int unsigned n, cnt;
      logic [31:0] d;
      n = cur_slot;
      cnt = nslots;
      r.none_ready = 1'b1;
      for (int unsigned i = 1; i <= cnt; i++) begin
        n++;
        if (n >= cnt) n = 0;
        if (!slot_used[n] || slot_st[n] == StBlocked) continue;
        if (slot_st[n] == StSleeping) begin
          d = slot_wake[n] - now;
          if (d != 0 && !d[31]) continue;
          slot_st[n] = StReady;
        end
        if (slot_st[n] == StTerm) begin
          r.reaped_valid = 1'b1;
          r.reaped_task_id = slot_id[n];
          drop(n);
          return;
        end
        r.none_ready = 1'b0;
        r.switched = (n != cur_slot);
        cur_slot = n;
        return;
      end
    endfunction

    function void note_request(req_t q);
      rsp_t r;
      int   k;
      bit   rescan;
      r = '0;
      rescan = 0;
      case (q.req_type)
        ReqAdd: r.error_code = insert_task(q.task_id, q.weight);
        ReqRemove, ReqTerm, ReqWake: begin
          k = lookup_id(q.task_id);
          if (k < 0) r.error_code = ErrNotFound;
          else if (q.req_type == ReqRemove) drop(k);
          else if (q.req_type == ReqTerm) slot_st[k] = StTerm;
          else if (slot_st[k] != StBlocked) r.error_code = ErrWake;
          else slot_st[k] = StReady;
        end
        ReqBlock: begin
          if (slot_used[cur_slot]) slot_st[cur_slot] = StBlocked;
          rescan = 1;
        end
        ReqSleep: if (q.sleep_us != 0) begin
          if (slot_used[cur_slot]) begin
            slot_wake[cur_slot] = q.now_ticks + q.sleep_us * {22'd0, tick_scale};
            slot_st[cur_slot] = StSleeping;
          end
          rescan = 1;
        end
        ReqYield: rescan = 1;
        default: ;
      endcase
      if (rescan) pick_next(q.now_ticks, r);
      r.cur_index = cur_slot[3:0];
      r.cur_task_id = slot_used[cur_slot] ? slot_id[cur_slot] : 8'd0;
      r.task_count = nslots[4:0];
      pending_rsp.push_back(r);
    endfunction

    task check_rsp(rsp_t got);
      rsp_t exp_r;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with nothing pending");
        return;
      end
      exp_r = pending_rsp.pop_front();
      if (got.cur_index !== exp_r.cur_index)
        report_mismatch($sformatf("cur_index %0d exp %0d", got.cur_index, exp_r.cur_index));
      if (got.cur_task_id !== exp_r.cur_task_id)
        report_mismatch($sformatf("cur_task_id %0d exp %0d", got.cur_task_id,
                                  exp_r.cur_task_id));
      if (got.switched !== exp_r.switched)
        report_mismatch($sformatf("switched %b exp %b", got.switched, exp_r.switched));
      if (got.none_ready !== exp_r.none_ready)
        report_mismatch($sformatf("none_ready %b exp %b", got.none_ready, exp_r.none_ready));
      if (got.reaped_valid !== exp_r.reaped_valid)
        report_mismatch($sformatf("reaped_valid %b exp %b", got.reaped_valid,
                                  exp_r.reaped_valid));
      if (got.reaped_task_id !== exp_r.reaped_task_id)
        report_mismatch($sformatf("reaped_task_id %0d exp %0d", got.reaped_task_id,
                                  exp_r.reaped_task_id));
      if (got.error_code !== exp_r.error_code)
        report_mismatch($sformatf("error_code %0d exp %0d", got.error_code, exp_r.error_code));
      if (got.task_count !== exp_r.task_count)
        report_mismatch($sformatf("task_count %0d exp %0d", got.task_count, exp_r.task_count));
    endtask

    task report_mismatch(string msg);
      err_cnt++;
      if (err_cnt <= 50) $display("MISMATCH @%0t: %s", $time, msg);
    endtask
  endclass

  localparam int StallLimit = 5000;  // idle cycles; the longest quiet stretch comes from drain

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       ticks_per_us_we_i;
  logic [9:0] ticks_per_us_wdata_i;
  logic       done_o;
  rsp_t       rsp_o;

  sched_scoreboard sb;
  int idle_cycles;
  logic [31:0] tick_now;  // time handed to the block, advanced on each random request

  weighted_round_robin_task_scheduler u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .req_i               (req_i),
    .ticks_per_us_we_i   (ticks_per_us_we_i),
    .ticks_per_us_wdata_i(ticks_per_us_wdata_i),
    .done_o              (done_o),
    .rsp_o               (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Response monitor: the block cannot be stalled, so every done cycle is a
  // transaction. A start transaction counts as activity too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_rsp(rsp_o);
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Issue one request; optional random hold-off first, then hold start until taken.
  // start stays high into a back-to-back request.
  task automatic send_req(logic [2:0] op, logic [7:0] id, logic [7:0] w,
                          logic [31:0] us, logic [31:0] now, bit gap_ok);
    req_t q;
    int   gap;
    gap = gap_ok ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    q.req_type = op;
    q.task_id = id;
    q.weight = w;
    q.sleep_us = us;
    q.now_ticks = now;
    req_i <= q;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_request(q);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [9:0] v);
    drain();
    ticks_per_us_we_i <= 1'b1;
    ticks_per_us_wdata_i <= v;
    @(posedge clk_i);
    ticks_per_us_we_i <= 1'b0;
    sb.tick_scale = v;
  endtask

  // Random request biased toward a live table: ids mostly from a small pool
  // so lookups hit; block, sleep and yield scans make up just under half.
  task automatic send_random(bit wide_time);
    logic [2:0]  op;
    logic [7:0]  id;
    logic [31:0] us;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) op = ReqAdd;
    else if (pick < 32) op = ReqRemove;
    else if (pick < 40) op = ReqTerm;
    else if (pick < 50) op = ReqWake;
    else if (pick < 62) op = ReqBlock;
    else if (pick < 77) op = ReqSleep;
    else if (pick < 98) op = ReqYield;
    else op = ReqUnused;
    id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 20));
    case ($urandom_range(0, 5))
      0: us = $urandom;
      1: us = 32'd0;
      default: us = $urandom_range(1, 40);
    endcase
    tick_now = tick_now + $urandom_range(0, 60);
    send_req(op, id, 8'($urandom), us, wide_time ? 32'($urandom) : tick_now, 1'b1);
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    tick_now = 32'hFFFF_FF00;  // crosses the wrap early
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    ticks_per_us_we_i = 1'b0;
    ticks_per_us_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table scans, lookup misses, unused code.
    send_req(ReqYield, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0);
    send_req(ReqBlock, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0);
    send_req(ReqSleep, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_req(ReqRemove, 8'hFF, 8'd0, 32'd0, 32'd0, 1'b0);
    send_req(ReqUnused, 8'hAA, 8'h55, 32'd0, 32'd0, 1'b0);
    // Fill to full with mixed weights, then one more for the full error.
    for (int i = 0; i < TaskSlots; i++)
      send_req(ReqAdd, 8'(i + 1), (i % 3 == 0) ? 8'd0 : 8'(i * 17), 32'd0, 32'd0, 1'b0);
    send_req(ReqAdd, 8'hFF, 8'hFF, 32'd0, 32'd0, 1'b0);
    send_req(ReqWake, 8'd2, 8'd0, 32'd0, 32'd0, 1'b0);         // not blocked
    send_req(ReqTerm, 8'd3, 8'd0, 32'd0, 32'd0, 1'b0);
    send_req(ReqSleep, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0);        // zero sleep
    send_req(ReqSleep, 8'd0, 8'd0, 32'd5, 32'h7FFF_FFF0, 1'b0);
    send_req(ReqBlock, 8'd0, 8'd0, 32'd0, 32'h7FFF_FFF0, 1'b0);
    for (int i = 0; i < 6; i++) send_req(ReqYield, 8'd0, 8'd0, 32'd0, 32'h8000_0010, 1'b0);

    // Random phases across scale settings, extremes included.
    write_scale(10'd1000);
    for (int i = 0; i < 120; i++) send_random(1'b0);
    write_scale(10'd1);
    for (int i = 0; i < 120; i++) send_random(1'b0);
    write_scale(10'h3FF);
    for (int i = 0; i < 60; i++) send_random(1'b1);
    write_scale(10'($urandom_range(2, 999)));
    for (int i = 0; i < 200; i++) send_random($urandom_range(0, 9) == 0);

    drain();
    if (sb.err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
